// ----- design/prq_pkg.sv -----
// Shared constants, codes and state type of the priority ready-queue scheduler.
package prq_pkg;

  localparam int unsigned PRIORITY_LEVELS_DEF = 32;
  localparam int unsigned THREAD_SLOTS_DEF    = 32;

  localparam int unsigned FIELD_W  = 5;
  localparam int unsigned IN_DW    = 16;
  localparam int unsigned OUT_DW   = 56;
  localparam int unsigned LEVELS_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SCHEDULE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_ALREADY     = 2'd1,
    ST_NOT_READY   = 2'd2,
    ST_NOTHING_RDY = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [LEVELS_W-1:0] ready_levels;
    logic [FIELD_W-1:0]  to_priority;
    logic [FIELD_W-1:0]  new_thread;
    logic [FIELD_W-1:0]  old_thread;
    logic                from_valid;
    logic                switched;
    status_e             status;
  } result_t;

endpackage

// ----- design/prq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module prq_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/priority_ready_queue_scheduler.sv -----
// Top level: bitmap ready-queue scheduler with per-level FIFOs kept in link RAMs.
// Each beat takes a RAM read at acceptance (IDLE) followed by the read-modify-write EXEC step that
// updates links, bitmap and current thread and registers the result for m_axis; no new beat is
// accepted until EXEC is done.
// Reset clears the ready bitmap, the per-thread ready bits, the current thread and the
// output valid flag; the link and level RAMs are not cleared and need no clearing pass.
module priority_ready_queue_scheduler #(
  parameter int unsigned PRIORITY_LEVELS = prq_pkg::PRIORITY_LEVELS_DEF,
  parameter int unsigned THREAD_SLOTS    = prq_pkg::THREAD_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // operation[1:0], thread_id[6:2], priority_req[11:7], zero pad[15:12]
  input  logic [prq_pkg::IN_DW-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], switched[2], from_valid[3], old_thread[8:4], new_thread[13:9],
  // to_priority[18:14], ready_levels[50:19], zero pad[55:51]
  output logic [prq_pkg::OUT_DW-1:0]  m_axis_tdata
);

  localparam int unsigned TW = $clog2(THREAD_SLOTS);
  localparam int unsigned LW = $clog2(PRIORITY_LEVELS);
  localparam int unsigned FW = prq_pkg::FIELD_W;
  // link value meaning "no neighbor"
  localparam logic [TW:0] NO_LINK  = (TW+1)'(THREAD_SLOTS);
  localparam logic [LW-1:0] LVL_MAX = LW'(PRIORITY_LEVELS - 1);

  // ---------------------------------------------------------------------------
  // Input beat unpacking
  // ---------------------------------------------------------------------------
  logic [1:0]    in_op;
  logic [FW-1:0] in_tid;
  logic [FW-1:0] in_prio;
  logic          in_tok;
  logic [TW-1:0] in_tix;
  logic [LW-1:0] in_lvl;
  logic          accept;

  assign in_op   = s_axis_tdata[1:0];
  assign in_tid  = s_axis_tdata[6:2];
  assign in_prio = s_axis_tdata[11:7];
  assign in_tok  = 32'(in_tid) < THREAD_SLOTS;
  assign in_tix  = in_tid[TW-1:0];
  // saturate out-of-range priorities to the lowest-priority (highest-numbered) level
  assign in_lvl  = (32'(in_prio) >= PRIORITY_LEVELS) ? LVL_MAX : in_prio[LW-1:0];

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  prq_pkg::state_e             state_q, state_d;
  logic [1:0]                  op_q;
  logic [FW-1:0]               tid_q;
  logic [LW-1:0]               lvl_q;
  logic [LW-1:0]               best_q;
  logic [PRIORITY_LEVELS-1:0]  bitmap_q, bitmap_d;
  logic [THREAD_SLOTS-1:0]     ready_q, ready_d;
  logic [TW-1:0]               cur_q, cur_d;
  logic                        cur_valid_q, cur_valid_d;
  logic                        out_valid_q;
  prq_pkg::result_t            out_q, res_d;

  // Lowest-numbered ready level, taken from the bitmap before the beat is
  // accepted; only EXEC changes the bitmap, so it still holds in EXEC.
  logic [LW-1:0] best;
  always_comb begin
    best = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (bitmap_q[i]) begin
        best = LW'(i);
      end
    end
  end

  // Accept only when idle and the output slot is free or draining this cycle.
  assign s_axis_tready = (state_q == prq_pkg::S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Link and level RAMs
  // ---------------------------------------------------------------------------
  logic          nx_we,  ex_nx_we;
  logic [TW-1:0] nx_wa,  ex_nx_wa;
  logic [TW:0]   nx_wd,  ex_nx_wd;
  logic [TW:0]   nx_rd;
  logic          pv_we;
  logic [TW-1:0] pv_wa;
  logic [TW:0]   pv_wd;
  logic [TW:0]   pv_rd;
  logic          tl_we;
  logic [LW-1:0] tl_rd;
  logic          hd_we;
  logic [LW-1:0] hd_wa;
  logic [TW-1:0] hd_wd;
  logic [TW-1:0] hd_rd;
  logic          tt_we;
  logic [LW-1:0] tt_wa;
  logic [TW-1:0] tt_wd;
  logic [TW-1:0] tt_rd;
  logic          acc_clear;

  // A fresh insert terminates its own next link right at acceptance, which
  // frees the next RAM's write port for the tail link in EXEC.
  assign acc_clear = accept && (in_op == prq_pkg::OP_INSERT) && in_tok && !ready_q[in_tix];
  assign nx_we     = acc_clear || ex_nx_we;
  assign nx_wa     = acc_clear ? in_tix  : ex_nx_wa;
  assign nx_wd     = acc_clear ? NO_LINK : ex_nx_wd;

  prq_ram #(.WIDTH(TW + 1), .DEPTH(THREAD_SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_wa),
    .wdata_i (nx_wd),
    .re_i    (accept),
    .raddr_i (in_tix),
    .rdata_o (nx_rd)
  );

  prq_ram #(.WIDTH(TW + 1), .DEPTH(THREAD_SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_wa),
    .wdata_i (pv_wd),
    .re_i    (accept),
    .raddr_i (in_tix),
    .rdata_o (pv_rd)
  );

  prq_ram #(.WIDTH(LW), .DEPTH(THREAD_SLOTS)) u_tlvl_ram (
    .clk_i   (clk_i),
    .we_i    (tl_we),
    .waddr_i (tid_q[TW-1:0]),
    .wdata_i (lvl_q),
    .re_i    (accept),
    .raddr_i (in_tix),
    .rdata_o (tl_rd)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (hd_wa),
    .wdata_i (hd_wd),
    .re_i    (accept),
    .raddr_i (best),
    .rdata_o (hd_rd)
  );

  prq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tt_we),
    .waddr_i (tt_wa),
    .wdata_i (tt_wd),
    .re_i    (accept),
    .raddr_i (in_lvl),
    .rdata_o (tt_rd)
  );

  // ---------------------------------------------------------------------------
  // Execute: read data is back, update links, bitmap and current thread
  // ---------------------------------------------------------------------------
  logic          ex;
  logic          t_ok;
  logic [TW-1:0] tix;
  logic          nonempty;
  logic          p_none, n_none;

  assign ex       = (state_q == prq_pkg::S_EXEC);
  assign t_ok     = 32'(tid_q) < THREAD_SLOTS;
  assign tix      = tid_q[TW-1:0];
  assign nonempty = bitmap_q[lvl_q];
  assign p_none   = pv_rd >= NO_LINK;
  assign n_none   = nx_rd >= NO_LINK;

  always_comb begin
    ex_nx_we    = 1'b0;
    ex_nx_wa    = tt_rd;
    ex_nx_wd    = {1'b0, tix};
    pv_we       = 1'b0;
    pv_wa       = tix;
    pv_wd       = NO_LINK;
    tl_we       = 1'b0;
    hd_we       = 1'b0;
    hd_wa       = lvl_q;
    hd_wd       = tix;
    tt_we       = 1'b0;
    tt_wa       = lvl_q;
    tt_wd       = tix;
    bitmap_d    = bitmap_q;
    ready_d     = ready_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    res_d       = '0;
    res_d.status = prq_pkg::ST_OK;

    unique case (op_q)
      prq_pkg::OP_INSERT: begin
        if (!t_ok) begin
          res_d.status = prq_pkg::ST_NOT_READY;
        end else if (ready_q[tix]) begin
          res_d.status = prq_pkg::ST_ALREADY;
        end else if (ex) begin
          // append at the tail of the level's FIFO
          tl_we = 1'b1;
          pv_we = 1'b1;
          tt_we = 1'b1;
          if (nonempty) begin
            pv_wd    = {1'b0, tt_rd};
            ex_nx_we = 1'b1;
          end else begin
            hd_we = 1'b1;
          end
          ready_d[tix]    = 1'b1;
          bitmap_d[lvl_q] = 1'b1;
        end
      end
      prq_pkg::OP_REMOVE: begin
        if (!t_ok || !ready_q[tix]) begin
          res_d.status = prq_pkg::ST_NOT_READY;
        end else if (ex) begin
          // unlink; neighbors or the level's head/tail take over the links
          hd_wa = tl_rd;
          tt_wa = tl_rd;
          hd_wd = nx_rd[TW-1:0];
          tt_wd = pv_rd[TW-1:0];
          if (p_none) begin
            hd_we = !n_none;
          end else begin
            ex_nx_we = 1'b1;
            ex_nx_wa = pv_rd[TW-1:0];
            ex_nx_wd = nx_rd;
          end
          if (n_none) begin
            tt_we = !p_none;
          end else begin
            pv_we = 1'b1;
            pv_wa = nx_rd[TW-1:0];
            pv_wd = pv_rd;
          end
          ready_d[tix] = 1'b0;
          if (p_none && n_none) begin
            bitmap_d[tl_rd] = 1'b0;
          end
        end
      end
      prq_pkg::OP_SCHEDULE: begin
        if (bitmap_q == '0) begin
          res_d.status = prq_pkg::ST_NOTHING_RDY;
        end else if (!cur_valid_q || (hd_rd != cur_q)) begin
          res_d.switched    = 1'b1;
          res_d.from_valid  = cur_valid_q;
          res_d.old_thread  = cur_valid_q ? FW'(cur_q) : '0;
          res_d.new_thread  = FW'(hd_rd);
          res_d.to_priority = FW'(best_q);
          if (ex) begin
            cur_d       = hd_rd;
            cur_valid_d = 1'b1;
          end
        end
      end
      default: begin
        // unknown code: report ok, change nothing
      end
    endcase

    res_d.ready_levels = prq_pkg::LEVELS_W'(bitmap_d);
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = prq_pkg::S_EXEC;
        end
      end
      prq_pkg::S_EXEC: begin
        state_d = prq_pkg::S_IDLE;
      end
      default: begin
        state_d = prq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prq_pkg::S_IDLE;
      bitmap_q    <= '0;
      ready_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ex) begin
        bitmap_q    <= bitmap_d;
        ready_q     <= ready_d;
        cur_q       <= cur_d;
        cur_valid_q <= cur_valid_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the beat fields and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      tid_q  <= in_tid;
      lvl_q  <= in_lvl;
      best_q <= best;
    end
    if (ex) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = prq_pkg::OUT_DW'(out_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // EXEC only ever loads a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex |-> !(out_valid_q && !m_axis_tready))
    else $error("result overwritten before it was taken");

  // a level bit is set exactly when some thread is ready
  a_bitmap_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bitmap_q == '0) == (ready_q == '0))
    else $error("ready bitmap disagrees with ready threads");

  // ready set and bitmap change only in the execute cycle
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex |=> ($stable(ready_q) && $stable(bitmap_q)))
    else $error("scheduler state changed outside execute");

  // one beat changes at most one thread's ready bit
  a_one_thread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex |=> $countones(ready_q ^ $past(ready_q)) <= 1)
    else $error("more than one ready bit changed in one beat");

endmodule
